[rtl/core/cspf_pkg.sv]
// Package for the C source prefilter: character constants, stripper modes and result types.
// Holds the per-byte stage functions used by the core.
// No dependencies.
package cspf_pkg;

	localparam int RES_MAX   = 6;
	localparam int RES_CNT_W = $clog2(RES_MAX + 1);

	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_LBRK    = 8'h5B;
	localparam logic [7:0] CH_RBRK    = 8'h5D;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_BAR     = 8'h7C;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_LESS    = 8'h3C;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_MINUS   = 8'h2D;

	typedef enum logic [7:0] {
		MODE_NORMAL     = 8'b0000_0001,
		MODE_SLASH      = 8'b0000_0010,
		MODE_STRING     = 8'b0000_0100,
		MODE_STRING_ESC = 8'b0000_1000,
		MODE_LINE       = 8'b0001_0000,
		MODE_BLOCK      = 8'b0010_0000,
		MODE_BLOCK_STAR = 8'b0100_0000,
		MODE_FAILED     = 8'b1000_0000
	} strip_mode_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_STRING = 2'd1,
		ERR_BLOCK  = 2'd2
	} err_code_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       last;
		err_code_t  err;
	} result_t;

	typedef struct packed {
		result_t [RES_MAX-1:0] items;
		logic [RES_CNT_W-1:0]  cnt;
	} result_list_t;

	// Persistent state of the three stages.
	typedef struct packed {
		logic [1:0]  qc;
		logic        held;
		strip_mode_t mode;
	} pf_state_t;

	// Working state while one request is evaluated.
	typedef struct packed {
		strip_mode_t  mode;
		logic         held;
		result_list_t res;
	} work_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} trig_t;

	function automatic result_t byte_result(input logic [7:0] b);
		result_t r;
		r.ch       = b;
		r.has_char = 1'b1;
		r.last     = 1'b0;
		r.err      = ERR_NONE;
		return r;
	endfunction

	// Appends one result; results beyond the list capacity are dropped.
	function automatic result_list_t list_push(input result_list_t l, input result_t r);
		result_list_t o;
		o = l;
		if (l.cnt < RES_CNT_W'(RES_MAX)) begin
			o.items[l.cnt] = r;
			o.cnt          = l.cnt + 1'b1;
		end
		return o;
	endfunction

	function automatic trig_t trigraph_of(input logic [7:0] b);
		trig_t t;
		t.hit = 1'b1;
		unique case (b)
			CH_EQUAL:   t.ch = CH_HASH;
			CH_LPAREN:  t.ch = CH_LBRK;
			CH_SLASH:   t.ch = CH_BSLASH;
			CH_RPAREN:  t.ch = CH_RBRK;
			CH_APOS:    t.ch = CH_CARET;
			CH_LESS:    t.ch = CH_LBRACE;
			CH_BANG:    t.ch = CH_BAR;
			CH_GREATER: t.ch = CH_RBRACE;
			CH_MINUS:   t.ch = CH_TILDE;
			default: begin
				t.hit = 1'b0;
				t.ch  = 8'h00;
			end
		endcase
		return t;
	endfunction

	function automatic work_t strip_normal(input work_t w, input logic [7:0] b);
		work_t o;
		o = w;
		if (b == CH_DQUOTE) begin
			o.res  = list_push(o.res, byte_result(b));
			o.mode = MODE_STRING;
		end else if (b == CH_SLASH) begin
			o.mode = MODE_SLASH;
		end else begin
			o.res = list_push(o.res, byte_result(b));
		end
		return o;
	endfunction

	// Comment stripper: one byte through the mode machine.
	function automatic work_t strip_step(input work_t w, input logic [7:0] b);
		work_t o;
		o = w;
		unique case (w.mode)
			MODE_NORMAL: o = strip_normal(w, b);
			MODE_SLASH: begin
				if (b == CH_SLASH) begin
					o.res  = list_push(o.res, byte_result(CH_SPACE));
					o.mode = MODE_LINE;
				end else if (b == CH_STAR) begin
					o.res  = list_push(o.res, byte_result(CH_SPACE));
					o.mode = MODE_BLOCK;
				end else begin
					o.res  = list_push(o.res, byte_result(CH_SLASH));
					o.mode = MODE_NORMAL;
					o      = strip_normal(o, b);
				end
			end
			MODE_STRING: begin
				if (b == CH_NL) begin
					o.mode = MODE_FAILED;
				end else begin
					o.res = list_push(o.res, byte_result(b));
					if (b == CH_DQUOTE) begin
						o.mode = MODE_NORMAL;
					end else if (b == CH_BSLASH) begin
						o.mode = MODE_STRING_ESC;
					end
				end
			end
			MODE_STRING_ESC: begin
				o.res  = list_push(o.res, byte_result(b));
				o.mode = MODE_STRING;
			end
			MODE_LINE: begin
				if (b == CH_NL) begin
					o.res  = list_push(o.res, byte_result(b));
					o.mode = MODE_NORMAL;
				end
			end
			MODE_BLOCK: begin
				if (b == CH_STAR) begin
					o.mode = MODE_BLOCK_STAR;
				end
			end
			MODE_BLOCK_STAR: begin
				if (b == CH_SLASH) begin
					o.mode = MODE_NORMAL;
				end else if (b != CH_STAR) begin
					o.mode = MODE_BLOCK;
				end
			end
			MODE_FAILED: o = w;
			default: o = w;
		endcase
		return o;
	endfunction

	// Line splicer: a held backslash is dropped together with a following newline.
	function automatic work_t splice_step(input work_t w, input logic [7:0] b);
		work_t o;
		logic  skip;
		o    = w;
		skip = 1'b0;
		if (w.held) begin
			o.held = 1'b0;
			if (b == CH_NL) begin
				skip = 1'b1;
			end else begin
				o = strip_step(o, CH_BSLASH);
			end
		end
		if (!skip) begin
			if (b == CH_BSLASH) begin
				o.held = 1'b1;
			end else begin
				o = strip_step(o, b);
			end
		end
		return o;
	endfunction

endpackage

[rtl/core/cspf_if.sv]
// Handshake channels of the C source prefilter: the byte input and the result output.
// Depends on nothing; payload widths are fixed by the byte format.
interface cspf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface cspf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       has_char;
	logic       out_last;
	logic [1:0] error_code;

	modport source (output valid, output out_char, output has_char, output out_last,
		output error_code, input ready);
	modport sink (input valid, input out_char, input has_char, input out_last,
		input error_code, output ready);
endinterface

[rtl/core/cspf_core.sv]
// Combinational evaluation of one source byte through trigraph, splice and strip stages.
// Depends on cspf_pkg for the stage functions and result types.
module cspf_core (
	input  cspf_pkg::pf_state_t    state,
	input  logic [7:0]             in_char,
	input  logic                   in_last,
	output cspf_pkg::pf_state_t    next_state,
	output cspf_pkg::result_list_t results
);

	always_comb begin
		cspf_pkg::work_t     w;
		cspf_pkg::trig_t     t;
		cspf_pkg::result_t   mark;
		logic [1:0]          qc;

		w.mode = state.mode;
		w.held = state.held;
		w.res  = '0;
		qc     = state.qc;
		t      = cspf_pkg::trigraph_of(in_char);

		if (in_char == cspf_pkg::CH_QUEST) begin
			if (qc < 2'd2) begin
				qc = qc + 2'd1;
			end else begin
				w = cspf_pkg::splice_step(w, cspf_pkg::CH_QUEST);
			end
		end else if (qc == 2'd2 && t.hit) begin
			qc = 2'd0;
			w  = cspf_pkg::splice_step(w, t.ch);
		end else begin
			if (qc != 2'd0) begin
				w = cspf_pkg::splice_step(w, cspf_pkg::CH_QUEST);
			end
			if (qc == 2'd2) begin
				w = cspf_pkg::splice_step(w, cspf_pkg::CH_QUEST);
			end
			qc = 2'd0;
			w  = cspf_pkg::splice_step(w, in_char);
		end

		mark.ch       = 8'h00;
		mark.has_char = 1'b0;
		mark.last     = 1'b1;
		mark.err      = cspf_pkg::ERR_NONE;

		if (in_last) begin
			if (qc != 2'd0) begin
				w = cspf_pkg::splice_step(w, cspf_pkg::CH_QUEST);
			end
			if (qc == 2'd2) begin
				w = cspf_pkg::splice_step(w, cspf_pkg::CH_QUEST);
			end
			qc = 2'd0;
			if (w.held) begin
				w.held = 1'b0;
				w      = cspf_pkg::strip_step(w, cspf_pkg::CH_BSLASH);
			end
			case (w.mode) inside
				cspf_pkg::MODE_SLASH: begin
					w.res = cspf_pkg::list_push(w.res, cspf_pkg::byte_result(cspf_pkg::CH_SLASH));
				end
				cspf_pkg::MODE_STRING, cspf_pkg::MODE_STRING_ESC, cspf_pkg::MODE_FAILED: begin
					mark.err = cspf_pkg::ERR_STRING;
				end
				cspf_pkg::MODE_BLOCK, cspf_pkg::MODE_BLOCK_STAR: begin
					mark.err = cspf_pkg::ERR_BLOCK;
				end
				default: mark.err = cspf_pkg::ERR_NONE;
			endcase
			w.res  = cspf_pkg::list_push(w.res, mark);
			w.mode = cspf_pkg::MODE_NORMAL;
			w.held = 1'b0;
		end

		next_state.qc   = qc;
		next_state.held = w.held;
		next_state.mode = w.mode;
		results         = w.res;
	end

endmodule

[rtl/core/c_source_prefilter.sv]
// The first result of a request is registered and appears in the cycle after it is accepted.
// Throughput: one result per cycle while the receiver is ready; a request holds the input until
// its results have been taken, so requests that give at most one result stream at one per cycle.
// The next request is taken in the cycle the last pending result is taken, set by the result queue.
// Reset (arst_n low) returns all stages to normal text and empties the result queue.
// Depends on cspf_pkg, cspf_if and cspf_core.
module c_source_prefilter (
	input  logic            clk,
	input  logic            arst_n,
	cspf_in_if.sink         text_ch,
	cspf_out_if.source      result_ch
);

	// Stage state: pending question marks, held backslash and the comment stripper mode.
	cspf_pkg::pf_state_t state_q;
	cspf_pkg::pf_state_t next_state;

	// Result queue. All results of one request are loaded at once and then shifted
	// out toward entry zero, which drives the output port directly.
	cspf_pkg::result_t [cspf_pkg::RES_MAX-1:0] buf_q;
	logic [cspf_pkg::RES_CNT_W-1:0]            cnt_q;
	cspf_pkg::result_list_t                    results;

	logic in_acc;
	logic out_acc;

	cspf_core u_core (
		.state      (state_q),
		.in_char    (text_ch.in_char),
		.in_last    (text_ch.in_last),
		.next_state (next_state),
		.results    (results)
	);

	// A new request is taken when the queue is empty, or when its final result
	// leaves in this very cycle.
	assign text_ch.ready = (cnt_q == '0) ||
		((cnt_q == cspf_pkg::RES_CNT_W'(1)) && result_ch.ready);
	assign in_acc  = text_ch.valid && text_ch.ready;

	assign result_ch.valid      = (cnt_q != '0);
	assign result_ch.out_char   = buf_q[0].ch;
	assign result_ch.has_char   = buf_q[0].has_char;
	assign result_ch.out_last   = buf_q[0].last;
	assign result_ch.error_code = 2'(buf_q[0].err);
	assign out_acc = result_ch.valid && result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.qc   <= 2'd0;
			state_q.held <= 1'b0;
			state_q.mode <= cspf_pkg::MODE_NORMAL;
			cnt_q        <= '0;
		end else begin
			if (in_acc) begin
				state_q <= next_state;
				cnt_q   <= results.cnt;
			end else if (out_acc) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Payload of the queue needs no reset; the count alone marks what is valid.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			buf_q <= results.items;
		end else if (out_acc) begin
			for (int i = 0; i < cspf_pkg::RES_MAX - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	// The queue never holds more than one request's worth of results.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cspf_pkg::RES_CNT_W'(cspf_pkg::RES_MAX))
		else $error("result queue count out of range");

	// A marker result always closes the text, and a byte result never does.
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> (result_ch.has_char != result_ch.out_last))
		else $error("marker and last flag disagree");

	// Byte results carry no error code.
	a_byte_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.has_char) |->
		(result_ch.error_code == 2'(cspf_pkg::ERR_NONE)))
		else $error("error code on a byte result");

	// After the final byte of a text, every stage is back in its reset state.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && text_ch.in_last) |=>
		(state_q.qc == 2'd0 && !state_q.held && state_q.mode == cspf_pkg::MODE_NORMAL))
		else $error("stage state not cleared at end of text");

endmodule

[test/tb_c_source_prefilter.sv]
`timescale 1ns / 1ps
// Self-checking testbench for c_source_prefilter: directed and random source texts go through
// the byte channel, and every result is checked against a predictor kept in this file.
// Depends on cspf_pkg, cspf_if and the c_source_prefilter RTL.
module tb_c_source_prefilter;
	import cspf_pkg::*;

	logic clk;
	logic arst_n;

	cspf_in_if  in_ch();
	cspf_out_if out_ch();

	c_source_prefilter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_ch   (in_ch),
		.result_ch (out_ch)
	);

	// Free-running 2 ns clock.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Predicted state of the three stages, updated once per accepted request.
	logic [1:0]  pf_qc;
	logic        pf_held;
	strip_mode_t pf_mode;
	int          step_results;

	// Results the block still owes us, oldest first.
	result_t filtered_stream[$];

	// Source text staged for sending; the final byte carries in_last.
	logic [7:0] text_buf[$];

	// The nine characters that complete a trigraph after two question marks.
	logic [7:0] tri_keys [9] = '{CH_EQUAL, CH_LPAREN, CH_SLASH, CH_RPAREN, CH_APOS,
		CH_LESS, CH_BANG, CH_GREATER, CH_MINUS};

	int mismatch_count = 0;
	int items_sent     = 0;

	// Flow control knobs shared between the test tasks and the receiver process.
	int src_gap_pct    = 25;
	int sink_stall_pct = 20;
	int hold_cycles    = 0;
	bit idle_off       = 1'b0;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// A request never yields more than RES_MAX results; anything beyond is dropped,
	// which matches the capacity of the block's result list.
	task automatic push_result(input logic [7:0] ch, input logic has, input logic last,
			input err_code_t err);
		result_t r;
		if (step_results < RES_MAX) begin
			r.ch       = ch;
			r.has_char = has;
			r.last     = last;
			r.err      = err;
			filtered_stream.push_back(r);
			step_results++;
		end
	endtask

	task automatic emit_char(input logic [7:0] ch);
		push_result(ch, 1'b1, 1'b0, ERR_NONE);
	endtask

	// Plain text: a quote opens a string, a slash may open a comment.
	task automatic strip_plain(input logic [7:0] b);
		if (b == CH_DQUOTE) begin
			emit_char(b);
			pf_mode = MODE_STRING;
		end else if (b == CH_SLASH) begin
			pf_mode = MODE_SLASH;
		end else begin
			emit_char(b);
		end
	endtask

	// Comment stripper. Each comment becomes a single space at the point it opens.
	task automatic strip_byte(input logic [7:0] b);
		case (pf_mode)
			MODE_NORMAL: strip_plain(b);
			MODE_SLASH: begin
				if (b == CH_SLASH) begin
					emit_char(CH_SPACE);
					pf_mode = MODE_LINE;
				end else if (b == CH_STAR) begin
					emit_char(CH_SPACE);
					pf_mode = MODE_BLOCK;
				end else begin
					// The slash was just a slash; the current byte is plain text again.
					emit_char(CH_SLASH);
					pf_mode = MODE_NORMAL;
					strip_plain(b);
				end
			end
			MODE_STRING: begin
				if (b == CH_NL) begin
					// A newline breaks the string; nothing more comes out until the end.
					pf_mode = MODE_FAILED;
				end else begin
					emit_char(b);
					if (b == CH_DQUOTE) begin
						pf_mode = MODE_NORMAL;
					end else if (b == CH_BSLASH) begin
						pf_mode = MODE_STRING_ESC;
					end
				end
			end
			MODE_STRING_ESC: begin
				emit_char(b);
				pf_mode = MODE_STRING;
			end
			MODE_LINE: begin
				if (b == CH_NL) begin
					emit_char(b);
					pf_mode = MODE_NORMAL;
				end
			end
			MODE_BLOCK: begin
				if (b == CH_STAR) begin
					pf_mode = MODE_BLOCK_STAR;
				end
			end
			MODE_BLOCK_STAR: begin
				if (b == CH_SLASH) begin
					pf_mode = MODE_NORMAL;
				end else if (b != CH_STAR) begin
					pf_mode = MODE_BLOCK;
				end
			end
			default: ;
		endcase
	endtask

	// Line splicer: a backslash is held back until we know whether a newline follows.
	task automatic splice_byte(input logic [7:0] b);
		logic dropped;
		dropped = 1'b0;
		if (pf_held) begin
			pf_held = 1'b0;
			if (b == CH_NL) begin
				dropped = 1'b1;
			end else begin
				strip_byte(CH_BSLASH);
			end
		end
		if (!dropped) begin
			if (b == CH_BSLASH) begin
				pf_held = 1'b1;
			end else begin
				strip_byte(b);
			end
		end
	endtask

	// Replacement for the third character of a trigraph, or zero when there is none.
	function automatic logic [7:0] trigraph_target(input logic [7:0] b);
		case (b)
			CH_EQUAL:   return CH_HASH;
			CH_LPAREN:  return CH_LBRK;
			CH_SLASH:   return CH_BSLASH;
			CH_RPAREN:  return CH_RBRK;
			CH_APOS:    return CH_CARET;
			CH_LESS:    return CH_LBRACE;
			CH_BANG:    return CH_BAR;
			CH_GREATER: return CH_RBRACE;
			CH_MINUS:   return CH_TILDE;
			default:    return 8'h00;
		endcase
	endfunction

	task automatic flush_questions();
		while (pf_qc != 2'd0) begin
			splice_byte(CH_QUEST);
			pf_qc = pf_qc - 2'd1;
		end
	endtask

	// Works out every result of one accepted request and queues them in order.
	task automatic filter_source_byte(input logic [7:0] b, input logic last);
		logic [7:0] t;
		err_code_t  err;
		step_results = 0;
		if (b == CH_QUEST) begin
			// Only the two most recent question marks can start a trigraph.
			if (pf_qc < 2'd2) begin
				pf_qc = pf_qc + 2'd1;
			end else begin
				splice_byte(CH_QUEST);
			end
		end else begin
			t = (pf_qc == 2'd2) ? trigraph_target(b) : 8'h00;
			if (t != 8'h00) begin
				pf_qc = 2'd0;
				splice_byte(t);
			end else begin
				flush_questions();
				splice_byte(b);
			end
		end
		if (last) begin
			// End of text: flush lookahead, then one marker with the verdict.
			flush_questions();
			if (pf_held) begin
				pf_held = 1'b0;
				strip_byte(CH_BSLASH);
			end
			err = ERR_NONE;
			case (pf_mode)
				MODE_SLASH: emit_char(CH_SLASH);
				MODE_STRING, MODE_STRING_ESC, MODE_FAILED: err = ERR_STRING;
				MODE_BLOCK, MODE_BLOCK_STAR: err = ERR_BLOCK;
				default: ;
			endcase
			push_result(8'h00, 1'b0, 1'b1, err);
			pf_qc   = 2'd0;
			pf_held = 1'b0;
			pf_mode = MODE_NORMAL;
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: ready with random stalls, and the checker
	// ------------------------------------------------------------------------

	// The receiver changes ready only at the falling edge. A long hold-off requested by a
	// test task is counted down here at each falling edge.
	initial begin : receiver
		int stall_left;
		int rx_cycle;
		stall_left   = 0;
		rx_cycle     = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			// The stall density is picked anew from time to time, zero included, so that stretches
			// without idling alternate with busy ones.
			if (rx_cycle % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: sink_stall_pct = 0;
					1: sink_stall_pct = 20;
					default: sink_stall_pct = 50;
				endcase
			end
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (idle_off) begin
				out_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < sink_stall_pct) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 6) - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Each taken result is compared with the oldest prediction. Sampling at the rising edge
	// sees the values that held just before it, so no race with the block's own updates.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (filtered_stream.size() == 0) begin
				$error("result with nothing predicted: out_char %h has_char %b out_last %b",
					out_ch.out_char, out_ch.has_char, out_ch.out_last);
				mismatch_count++;
			end else begin
				exp_r = filtered_stream.pop_front();
				if (out_ch.out_char !== exp_r.ch) begin
					$error("out_char expected %h actual %h", exp_r.ch, out_ch.out_char);
					mismatch_count++;
				end
				if (out_ch.has_char !== exp_r.has_char) begin
					$error("has_char expected %b actual %b", exp_r.has_char, out_ch.has_char);
					mismatch_count++;
				end
				if (out_ch.out_last !== exp_r.last) begin
					$error("out_last expected %b actual %b", exp_r.last, out_ch.out_last);
					mismatch_count++;
				end
				if (out_ch.error_code !== exp_r.err) begin
					$error("error_code expected %0d actual %0d", exp_r.err, out_ch.error_code);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offers one byte, waits for the handshake, and predicts its results once it is taken.
	// Called and returns at a falling edge. Valid is only lowered when a gap is inserted,
	// so back-to-back requests keep valid high without a glitch.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!idle_off && src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_char <= b;
		in_ch.in_last <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		filter_source_byte(b, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++) begin
			send_byte(text_buf[i], i == text_buf.size() - 1);
		end
	endtask

	task automatic load_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) begin
			text_buf.push_back(s[i]);
		end
	endtask

	// Stops offering and waits until every predicted result has been taken.
	task automatic wait_until_drained();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (filtered_stream.size() != 0);
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	// Mostly lowercase letters, sometimes any nonzero byte.
	function automatic logic [7:0] plain_byte();
		if ($urandom_range(0, 3) != 0) begin
			return 8'($urandom_range(8'h61, 8'h7A));
		end
		return any_byte();
	endfunction

	// Builds one text out of C-like pieces: trigraphs, splices, strings and comments with
	// random content, plus the odd broken piece. A small share is pure noise.
	task automatic build_random_text();
		int target;
		int r;
		text_buf.delete();
		target = $urandom_range(3, 24);
		if ($urandom_range(0, 99) < 12) begin
			repeat (target) text_buf.push_back(any_byte());
		end else begin
			while (text_buf.size() < target) begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						repeat ($urandom_range(1, 3)) text_buf.push_back(plain_byte());
					end
					3: begin
						text_buf.push_back(CH_QUEST);
						text_buf.push_back(CH_QUEST);
						if ($urandom_range(0, 3) != 0) begin
							text_buf.push_back(tri_keys[$urandom_range(0, 8)]);
						end else begin
							text_buf.push_back(any_byte());
						end
					end
					4: begin
						repeat ($urandom_range(1, 4)) text_buf.push_back(CH_QUEST);
					end
					5: begin
						r = $urandom_range(0, 3);
						if (r == 0) begin
							// Backslash spelled as a trigraph, then spliced away.
							text_buf.push_back(CH_QUEST);
							text_buf.push_back(CH_QUEST);
							text_buf.push_back(CH_SLASH);
							text_buf.push_back(CH_NL);
						end else begin
							text_buf.push_back(CH_BSLASH);
							text_buf.push_back((r == 3) ? any_byte() : CH_NL);
						end
					end
					6: begin
						text_buf.push_back(CH_DQUOTE);
						repeat ($urandom_range(0, 5)) begin
							r = $urandom_range(0, 4);
							if (r < 3) begin
								text_buf.push_back(plain_byte());
							end else begin
								text_buf.push_back(CH_BSLASH);
								case ($urandom_range(0, 2))
									0: text_buf.push_back(CH_DQUOTE);
									1: text_buf.push_back(CH_BSLASH);
									default: text_buf.push_back(any_byte());
								endcase
							end
						end
						r = $urandom_range(0, 7);
						if (r < 6) begin
							text_buf.push_back(CH_DQUOTE);
						end else if (r == 6) begin
							text_buf.push_back(CH_NL);
						end
					end
					7: begin
						text_buf.push_back(CH_SLASH);
						text_buf.push_back(CH_SLASH);
						repeat ($urandom_range(0, 4)) text_buf.push_back(plain_byte());
						if ($urandom_range(0, 4) != 0) text_buf.push_back(CH_NL);
					end
					8: begin
						text_buf.push_back(CH_SLASH);
						text_buf.push_back(CH_STAR);
						repeat ($urandom_range(0, 4)) begin
							case ($urandom_range(0, 3))
								0: text_buf.push_back(CH_STAR);
								1: text_buf.push_back(CH_SLASH);
								default: text_buf.push_back(plain_byte());
							endcase
						end
						if ($urandom_range(0, 5) != 0) begin
							text_buf.push_back(CH_STAR);
							text_buf.push_back(CH_SLASH);
						end
					end
					default: begin
						case ($urandom_range(0, 5))
							0: text_buf.push_back(CH_SLASH);
							1: text_buf.push_back(CH_STAR);
							2: text_buf.push_back(CH_NL);
							3: text_buf.push_back(CH_DQUOTE);
							4: text_buf.push_back(CH_BSLASH);
							default: text_buf.push_back(CH_QUEST);
						endcase
					end
				endcase
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Three question marks: the first passes, the last two form a trigraph.
	// A lone question mark comes out together with the byte after it.
	task automatic test_trigraphs();
		load_text("???-");
		send_text();
		load_text("?a??(");
		send_text();
	endtask

	// Trigraph backslash spliced with a newline, between the largest and the smallest nonzero byte;
	// then a backslash held at the very end, which must be flushed.
	task automatic test_splices();
		load_text("??/\n");
		text_buf.push_front(8'hFF);
		text_buf.push_back(8'h01);
		send_text();
		load_text("a\\");
		send_text();
	endtask

	// Escaped quote inside a string, then a newline that leaves it unterminated: the bytes
	// after it vanish and the end marker reports the string error.
	task automatic test_strings();
		load_text("\"a\\\"b\nc");
		send_text();
	endtask

	// Block comment closed by a run of stars, a slash pending at the end, a line comment
	// cut off by the end of text, and a block comment that never closes.
	task automatic test_comments();
		load_text("/***/y/");
		send_text();
		load_text("//q");
		send_text();
		load_text("/*");
		send_text();
	endtask

	// Bulk of the run: random texts with random gaps on both sides.
	task automatic test_random_traffic(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 2))
				0: src_gap_pct = 0;
				1: src_gap_pct = 20;
				default: src_gap_pct = 50;
			endcase
			build_random_text();
			send_text();
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering requests
	// back to back, so the result queue fills and the input stalls.
	task automatic test_receiver_hold();
		int stop_at;
		src_gap_pct = 0;
		hold_cycles = 80;
		stop_at     = items_sent + 30;
		while (items_sent < stop_at) begin
			build_random_text();
			send_text();
		end
		wait_until_drained();
	endtask

	// The sender stops after each text until every predicted result has been taken.
	task automatic test_sender_pause();
		src_gap_pct = 20;
		repeat (3) begin
			build_random_text();
			send_text();
			wait_until_drained();
		end
	endtask

	// Final stretch: full rate on both sides.
	task automatic test_full_rate(input int n_items);
		int stop_at;
		idle_off = 1'b1;
		stop_at  = items_sent + n_items;
		while (items_sent < stop_at) begin
			build_random_text();
			send_text();
		end
	endtask

	initial begin : main
		pf_qc         = 2'd0;
		pf_held       = 1'b0;
		pf_mode       = MODE_NORMAL;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.in_char = 8'h00;
		in_ch.in_last = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_trigraphs();
		test_splices();
		test_strings();
		test_comments();
		test_random_traffic(220);
		test_receiver_hold();
		test_sender_pause();
		test_full_rate(70);

		// Let any stray result show up after the last prediction is consumed.
		wait_until_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[c_source_prefilter] OK");
		end else begin
			$display("[c_source_prefilter] ERROR");
		end
		$finish;
	end

	// Watchdog: ends the run with an error at several times the length of the slowest legal run,
	// which holds even when every request gives six results under the longest stalls.
	initial begin : watchdog
		#200000;
		$display("[c_source_prefilter] ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/cspf_pkg.sv
rtl/core/cspf_if.sv
rtl/core/cspf_core.sv
rtl/core/c_source_prefilter.sv
test/tb_c_source_prefilter.sv
